// ===== rtl/assert_macros.svh =====
// assertion macros for the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMPL(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error("assertion failed");
`define ASSERT_NORST(label, clk, prop) \
  label: assert property (@(posedge clk) (prop)) else $error("assertion failed");
`else
`define ASSERT_IMPL(label, clk, rst, prop)
`define ASSERT_NORST(label, clk, prop)
`endif
`endif

// ===== rtl/ffba_pkg.sv =====
`default_nettype none
package ffba_pkg;
  localparam int unsigned UNIT_BYTES = 16;
  localparam int unsigned ACT_ALLOC = 0;
  localparam int unsigned ACT_FREE = 1;
  localparam logic [1:0] ST_GRANT = 2'd0;
  localparam logic [1:0] ST_FAIL = 2'd1;
  localparam logic [1:0] ST_FREED = 2'd2;
  typedef enum logic [4:0] {
    S_IDLE, S_INIT, S_AREAD, S_AWAIT, S_ACHK, S_AUNL0, S_AUNL1, S_ACARVE0, S_ACARVE1,
    S_FREAD, S_FWAIT, S_FCHK, S_FHDR, S_FHWAIT, S_FNX, S_FNXWAIT, S_FP, S_FPWAIT,
    S_FW0, S_FW1, S_FW2, S_FW3, S_FW4, S_OUT
  } state_t;
endpackage
`default_nettype wire

// ===== rtl/ffba_ram.sv =====
`default_nettype none
module ffba_ram #(
  parameter int unsigned WIDTH = 11,
  parameter int unsigned DEPTH = 1025
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ===== rtl/first_fit_block_allocator_core.sv =====
// next-fit block allocator (search starts at a rover) with coalescing free list
// s_axis: one request transaction; s_tuser is the action (0 allocate, 1 free),
//   s_tdata from the lowest bit: request_bytes (16), block_unit (10), pad
// m_axis: one result transaction per request; m_tuser is the status,
//   m_tdata from the lowest bit: payload_unit (10), pad
// the free list lives in three header memories (next, prev, size) with one
// registered read port each; every list step is a read and then a compare
// an allocate reads the start entry and then walks the list; a grant also writes
// two headers, and the first allocate sets up the arena before its walk; a free
// walks the list, reads the block headers and then does 1 to 5 header writes;
// an ignored free goes straight to its result
// the walk is bounded by ARENA_UNITS + 2 entries
// s_tready is high only in idle: one request is in work at a time, and the next
// can be accepted in the cycle after the result transaction
// while m_tready is low the result is held and the input stays stalled
// rst (synchronous) sets the rover to the sentinel and marks the arena as not
// set up, with no clearing pass; headers never written read as undefined
`default_nettype none
`include "assert_macros.svh"
module first_fit_block_allocator_core #(
  parameter int unsigned ARENA_UNITS = 1024
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic        s_tuser,  // action
  input  wire logic [31:0] s_tdata,  // request_bytes, block_unit
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [1:0]       m_tuser,  // status
  output logic [15:0]      m_tdata   // payload_unit
);
  import ffba_pkg::*;
  localparam int unsigned AW = $clog2(ARENA_UNITS + 1);
  localparam int unsigned SW = $clog2(UNIT_BYTES);
  localparam int unsigned QW = 18 - SW;
  localparam int unsigned NW = (AW + 1 > QW) ? AW + 1 : QW;
  localparam logic [AW-1:0] SENT = AW'(ARENA_UNITS);
  localparam logic [AW:0] WLIM = (AW+1)'(ARENA_UNITS + 2);

  state_t state, state_next;
  logic [AW-1:0] rover, start, p, nx, bp, nn, pv, waddr, raddr;
  logic [AW-1:0] sz, szp, bsz, wdata;
  logic [NW-1:0] need;
  logic [AW:0] cnt;
  logic [AW-1:0] next_q, prev_q, size_q;
  logic arena_ready;
  logic [1:0] st;
  logic [9:0] pay;
  logic we_n, we_p, we_s;

  ffba_ram #(.WIDTH(AW), .DEPTH(ARENA_UNITS + 1)) u_next (
    .clk, .we(we_n), .waddr, .wdata, .raddr, .rdata(next_q));
  ffba_ram #(.WIDTH(AW), .DEPTH(ARENA_UNITS + 1)) u_prev (
    .clk, .we(we_p), .waddr, .wdata, .raddr, .rdata(prev_q));
  ffba_ram #(.WIDTH(AW), .DEPTH(ARENA_UNITS + 1)) u_size (
    .clk, .we(we_s), .waddr, .wdata, .raddr, .rdata(size_q));

  function automatic logic [AW:0] ord(input logic [AW-1:0] i);
    return (i == SENT) ? '0 : {1'b0, i} + 1'b1;
  endfunction

  logic in_range, wrap;
  assign in_range = ord(bp) > ord(p) && ord(bp) < ord(next_q);
  assign wrap = ord(p) >= ord(next_q) && (ord(bp) > ord(p) || ord(bp) < ord(next_q));

  logic [16:0] nbytes;
  assign nbytes = {1'b0, s_tdata[15:0]} + 17'(UNIT_BYTES - 1);

  assign s_tready = state == S_IDLE;
  assign m_tvalid = state == S_OUT;
  assign m_tuser = st;
  assign m_tdata = {6'd0, pay};

  logic up, low;
  assign up = nx != SENT && (bp + bsz) == nx;
  assign low = p != SENT && (p + szp) == bp;

  // memory read and write ports and next state
  logic [2:0] init_step, init_next;
  always_comb begin
    state_next = state;
    we_n = 1'b0;
    we_p = 1'b0;
    we_s = 1'b0;
    waddr = '0;
    wdata = '0;
    raddr = p;
    init_next = init_step;
    case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          if (s_tuser == 1'(ACT_ALLOC)) begin
            state_next = arena_ready ? S_AREAD : S_INIT;
          end else if (!arena_ready || s_tdata[25:16] == 10'd0 ||
                       32'(s_tdata[25:16]) > 32'(SENT)) begin
            state_next = S_OUT;
          end else begin
            state_next = S_FREAD;
          end
        end
      end
      S_INIT: begin
        case (init_step)
          3'd0: begin we_n = 1'b1; waddr = '0; wdata = SENT; end
          3'd1: begin we_p = 1'b1; waddr = '0; wdata = SENT; end
          3'd2: begin we_s = 1'b1; waddr = '0; wdata = SENT - 1'b1; end
          3'd3: begin we_n = 1'b1; waddr = SENT; wdata = '0; end
          3'd4: begin we_p = 1'b1; waddr = SENT; wdata = '0; end
          default: begin we_s = 1'b1; waddr = SENT; wdata = '0; end
        endcase
        init_next = init_step + 3'd1;
        if (init_step == 3'd5) begin
          state_next = S_AREAD;
        end
      end
      S_AREAD: begin
        raddr = start;
        state_next = S_AWAIT;
      end
      S_AWAIT: begin
        state_next = S_ACHK;
      end
      S_ACHK: begin
        state_next = S_AWAIT;
        raddr = next_q;
        if (cnt == '0 && p == '1) begin
          raddr = next_q;
        end
        if (cnt != '0) begin
          if (p != SENT && NW'(size_q) >= need) begin
            state_next = (NW'(size_q) == need) ? S_AUNL0 : S_ACARVE0;
          end else if (p == start || cnt == WLIM) begin
            state_next = S_OUT;
          end
        end
      end
      S_AUNL0: begin
        we_n = 1'b1; waddr = pv; wdata = nx; state_next = S_AUNL1;
      end
      S_AUNL1: begin
        we_p = 1'b1; waddr = nx; wdata = pv; state_next = S_OUT;
      end
      S_ACARVE0: begin
        we_s = 1'b1; waddr = p; wdata = sz - need[AW-1:0]; state_next = S_ACARVE1;
      end
      S_ACARVE1: begin
        we_s = 1'b1; waddr = p + sz - need[AW-1:0]; wdata = need[AW-1:0];
        state_next = S_OUT;
      end
      S_FREAD: begin
        raddr = p; state_next = S_FWAIT;
      end
      S_FWAIT: begin
        state_next = S_FCHK;
      end
      S_FCHK: begin
        raddr = next_q;
        if (in_range || wrap) begin
          raddr = bp; state_next = S_FHDR;
        end else if (cnt == WLIM - 1'b1) begin
          state_next = S_OUT;
        end else begin
          state_next = S_FWAIT;
        end
      end
      S_FHDR: begin raddr = nx; state_next = S_FHWAIT; end
      S_FHWAIT: begin raddr = p; state_next = S_FNX; end
      S_FNX: begin state_next = S_FNXWAIT; end
      S_FNXWAIT: begin state_next = S_FP; end
      S_FP: begin state_next = S_FW0; end
      S_FW0: begin
        state_next = S_FW1;
        if (up && low) begin
          we_s = 1'b1; waddr = p; wdata = szp + bsz + sz;
        end else if (up) begin
          we_s = 1'b1; waddr = bp; wdata = bsz + sz;
        end else if (low) begin
          we_s = 1'b1; waddr = p; wdata = szp + bsz; state_next = S_OUT;
        end else begin
          we_n = 1'b1; waddr = bp; wdata = nx;
        end
      end
      S_FW1: begin
        state_next = S_FW2;
        if (up && low) begin
          we_p = 1'b1; waddr = nn; wdata = p;
        end else if (up) begin
          we_n = 1'b1; waddr = bp; wdata = nn;
        end else begin
          we_p = 1'b1; waddr = bp; wdata = p;
        end
      end
      S_FW2: begin
        state_next = S_FW3;
        if (up && low) begin
          we_n = 1'b1; waddr = p; wdata = nn; state_next = S_OUT;
        end else if (up) begin
          we_p = 1'b1; waddr = bp; wdata = pv;
        end else begin
          we_p = 1'b1; waddr = nx; wdata = bp;
        end
      end
      S_FW3: begin
        state_next = up ? S_FW4 : S_OUT;
        if (up) begin
          we_p = 1'b1; waddr = nn; wdata = bp;
        end else begin
          we_n = 1'b1; waddr = p; wdata = bp;
        end
      end
      S_FW4: begin
        we_n = 1'b1; waddr = p; wdata = bp; state_next = S_OUT;
      end
      S_OUT: begin
        if (m_tready) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      rover <= SENT;
      arena_ready <= 1'b0;
      init_step <= '0;
    end else begin
      state <= state_next;
      init_step <= init_next;
      if (state == S_INIT && init_step == 3'd5) begin
        arena_ready <= 1'b1;
        rover <= SENT;
      end
      if (state == S_ACHK && state_next != S_AWAIT && state_next != S_OUT) begin
        rover <= prev_q;
      end
      if (state == S_FP) begin
        rover <= p;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        need <= NW'((nbytes >> SW) + 17'd1);
        bp <= AW'(s_tdata[25:16]) - 1'b1;
        p <= rover;
        start <= (s_tuser == 1'(ACT_ALLOC) && !arena_ready) ? SENT : rover;
        cnt <= '0;
        st <= s_tuser == 1'(ACT_FREE) ? ST_FREED : ST_FAIL;
        pay <= '0;
      end
      S_AREAD: p <= start;
      S_ACHK: begin
        if (cnt == '0) begin
          p <= next_q;
          cnt <= cnt + 1'b1;
        end else begin
          sz <= size_q;
          pv <= prev_q;
          nx <= next_q;
          if (p != SENT && NW'(size_q) >= need) begin
            st <= ST_GRANT;
            if (NW'(size_q) == need) begin
              pay <= 10'(p + 1'b1);
            end else begin
              pay <= 10'(p + size_q - need[AW-1:0] + 1'b1);
            end
          end else begin
            p <= next_q;
            cnt <= cnt + 1'b1;
          end
        end
      end
      S_FCHK: begin
        nx <= next_q;
        szp <= size_q;
        if (!(in_range || wrap)) begin
          p <= next_q;
          cnt <= cnt + 1'b1;
        end
      end
      S_FHDR: bsz <= size_q;
      S_FHWAIT: begin
        sz <= size_q;
        nn <= next_q;
        pv <= prev_q;
      end
      default: ;
    endcase
  end

  `ASSERT_IMPL(a_out_hold, clk, rst, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
  `ASSERT_IMPL(a_no_accept_busy, clk, rst, m_tvalid |-> !s_tready)
  `ASSERT_IMPL(a_pay_zero, clk, rst, m_tvalid && m_tuser != ST_GRANT |-> m_tdata == 16'd0)
  `ASSERT_IMPL(a_ready_ok, clk, rst, arena_ready |=> arena_ready)
endmodule
`default_nettype wire
